// ===== sv/scmr_pkg.sv =====
// ----------------------------------------------------------------------------
// scmr_pkg
// Shared types and constants for the slot/channel resource map.
// ----------------------------------------------------------------------------
`default_nettype none

package scmr_pkg;

  localparam int NUM_SLOTS    = 64;
  localparam int NUM_CHANNELS = 16;

  localparam int SLOT_W  = 6;
  localparam int CHAN_W  = 6;
  localparam int MAP_W   = 64;
  localparam int CNT_W   = 7;
  localparam int DEPTH   = 64;
  localparam int ENTRY_W = MAP_W + CNT_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [1:0] {
    CMD_BUILD = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_REJECT  = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_FIRST = 2'd0,
    REG_SLOT_LAST  = 2'd1,
    REG_CHAN_FIRST = 2'd2,
    REG_CHAN_LAST  = 2'd3
  } reg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // item transfer
    logic exec;   // lookup data valid, decode item
    logic sweep;  // one build write
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic build_go;    // good build range, sweep needed
    logic sweep_last;  // current sweep entry is the last
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/slot_channel_resource_map.sv =====
// ----------------------------------------------------------------------------
// slot_channel_resource_map
// Per-slot usable channel bitmap and free count with build, mark and read.
//
//   port group   handshake            payload
//   cfg          cfg_we               cfg_idx, cfg_wdata
//   input        start & !busy        in_cmd, in_slot_sel, in_chan_sel
//   result       out_valid (1 cycle)  out_status, out_chan_map,
//                                     out_free_chans, out_slots_in_use
//
// Mark and read: the slot table read is registered at item load, and the
// exec state decodes the item; a mark that clears a bit writes back there. Rejected build: ends after exec.
// Good build: exec, then a sweep with one table write per slot in the range.
// The result strobe comes in the first cycle with busy low. Reset is synchronous;
// the table needs no clearing pass (per-entry valid flops). No output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_channel_resource_map (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [scmr_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [scmr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [1:0]                           in_cmd,
  input  wire logic [scmr_pkg::SLOT_W-1:0]          in_slot_sel,
  input  wire logic [scmr_pkg::CHAN_W-1:0]          in_chan_sel,
  output logic                                      out_valid,
  output logic [1:0]                                out_status,
  output logic [scmr_pkg::MAP_W-1:0]                out_chan_map,
  output logic [scmr_pkg::CNT_W-1:0]                out_free_chans,
  output logic [scmr_pkg::CNT_W-1:0]                out_slots_in_use
);

  scmr_pkg::ctrl_cmd_t cmd;
  scmr_pkg::dp_stat_t  stat;

  scmr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  scmr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .in_cmd           (in_cmd),
    .in_slot_sel      (in_slot_sel),
    .in_chan_sel      (in_chan_sel),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_chan_map     (out_chan_map),
    .out_free_chans   (out_free_chans),
    .out_slots_in_use (out_slots_in_use)
  );

endmodule

`default_nettype wire

// ===== sv/scmr_ram.sv =====
// ----------------------------------------------------------------------------
// scmr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/scmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// scmr_ctrl
// Item sequencer: accept, execute, build sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module scmr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output scmr_pkg::ctrl_cmd_t     cmd,
  input  wire scmr_pkg::dp_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_BUILD = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = stat.build_go ? S_BUILD : S_IDLE;
      end
      S_BUILD: begin
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cmd.load  = (state_r == S_IDLE) && start;
  assign cmd.exec  = (state_r == S_EXEC);
  assign cmd.sweep = (state_r == S_BUILD);

endmodule

`default_nettype wire

// ===== sv/scmr_dp.sv =====
// ----------------------------------------------------------------------------
// scmr_dp
// Config registers, range registers, slot table and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module scmr_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire scmr_pkg::ctrl_cmd_t                  cmd,
  output scmr_pkg::dp_stat_t                        stat,
  input  wire logic                                 cfg_we,
  input  wire logic [scmr_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [scmr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic [1:0]                           in_cmd,
  input  wire logic [scmr_pkg::SLOT_W-1:0]          in_slot_sel,
  input  wire logic [scmr_pkg::CHAN_W-1:0]          in_chan_sel,
  output logic                                      out_valid,
  output logic [1:0]                                out_status,
  output logic [scmr_pkg::MAP_W-1:0]                out_chan_map,
  output logic [scmr_pkg::CNT_W-1:0]                out_free_chans,
  output logic [scmr_pkg::CNT_W-1:0]                out_slots_in_use
);

  localparam int SW = scmr_pkg::SLOT_W;
  localparam int CW = scmr_pkg::CHAN_W;
  localparam int MW = scmr_pkg::MAP_W;
  localparam int NW = scmr_pkg::CNT_W;

  // config
  logic [SW-1:0] slot_first_r, slot_last_r;
  logic [CW-1:0] chan_first_r, chan_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_first_r <= '0;
      slot_last_r  <= '0;
      chan_first_r <= '0;
      chan_last_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        scmr_pkg::REG_SLOT_FIRST: slot_first_r <= cfg_wdata[SW-1:0];
        scmr_pkg::REG_SLOT_LAST:  slot_last_r  <= cfg_wdata[SW-1:0];
        scmr_pkg::REG_CHAN_FIRST: chan_first_r <= cfg_wdata[CW-1:0];
        scmr_pkg::REG_CHAN_LAST:  chan_last_r  <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // item
  logic [1:0]    cmd_r;
  logic [SW-1:0] slot_r;
  logic [CW-1:0] chan_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_cmd;
      slot_r <= in_slot_sel;
      chan_r <= in_chan_sel;
    end
  end

  logic is_build, is_mark;
  assign is_build = (cmd_r == scmr_pkg::CMD_BUILD);
  assign is_mark  = (cmd_r == scmr_pkg::CMD_MARK);

  // range
  logic          range_valid_r;
  logic [SW-1:0] range_slot_lo_r, range_slot_hi_r;
  logic [CW-1:0] range_chan_lo_r, range_chan_hi_r;
  logic [NW-1:0] range_count_r;
  logic          range_ok;

  assign range_ok = (slot_last_r >= slot_first_r) && (chan_last_r >= chan_first_r) &&
                    ({1'b0, slot_last_r} < NW'(scmr_pkg::NUM_SLOTS)) &&
                    ({1'b0, chan_last_r} < NW'(scmr_pkg::NUM_CHANNELS));

  logic build_go;
  assign build_go = cmd.exec && is_build && range_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_valid_r   <= 1'b0;
      range_slot_lo_r <= '0;
      range_slot_hi_r <= '0;
      range_chan_lo_r <= '0;
      range_chan_hi_r <= '0;
      range_count_r   <= '0;
    end else if (build_go) begin
      range_valid_r   <= 1'b1;
      range_slot_lo_r <= slot_first_r;
      range_slot_hi_r <= slot_last_r;
      range_chan_lo_r <= chan_first_r;
      range_chan_hi_r <= chan_last_r;
      range_count_r   <= NW'({1'b0, slot_last_r} - {1'b0, slot_first_r} + NW'(1));
    end
  end

  // sweep pointer
  logic [SW-1:0] ptr_r;
  logic          sweep_last;

  always_ff @(posedge clk) begin
    if (build_go) begin
      ptr_r <= slot_first_r;
    end else if (cmd.sweep) begin
      ptr_r <= ptr_r + SW'(1);
    end
  end

  assign sweep_last = (ptr_r == range_slot_hi_r);

  logic [MW-1:0] build_map;
  logic [NW-1:0] build_cnt;
  assign build_map = ({MW{1'b1}} << range_chan_lo_r) &
                     ({MW{1'b1}} >> (CW'(MW - 1) - range_chan_hi_r));
  assign build_cnt = NW'({1'b0, range_chan_hi_r} - {1'b0, range_chan_lo_r} + NW'(1));

  // table: entries never written read as zero
  logic [scmr_pkg::DEPTH-1:0]   valid_r;
  logic [scmr_pkg::ENTRY_W-1:0] rd_entry;
  logic [MW-1:0]                cur_map, new_map, chan_bit;
  logic [NW-1:0]                cur_cnt, new_cnt;
  logic                         in_range, bit_set, mark_wr;
  logic                         ram_we;
  logic [SW-1:0]                ram_waddr;
  logic [scmr_pkg::ENTRY_W-1:0] ram_wdata;

  assign cur_map  = valid_r[slot_r] ? rd_entry[MW-1:0] : '0;
  assign cur_cnt  = valid_r[slot_r] ? rd_entry[scmr_pkg::ENTRY_W-1:MW] : '0;
  assign chan_bit = MW'(1) << chan_r;
  assign in_range = range_valid_r &&
                    (slot_r >= range_slot_lo_r) && (slot_r <= range_slot_hi_r) &&
                    (chan_r >= range_chan_lo_r) && (chan_r <= range_chan_hi_r);
  assign bit_set  = |(cur_map & chan_bit);
  assign mark_wr  = cmd.exec && is_mark && in_range && bit_set;
  assign new_map  = mark_wr ? (cur_map & ~chan_bit) : cur_map;
  assign new_cnt  = (mark_wr && (cur_cnt != '0)) ? (cur_cnt - NW'(1)) : cur_cnt;

  assign ram_we    = mark_wr || cmd.sweep;
  assign ram_waddr = cmd.sweep ? ptr_r : slot_r;
  assign ram_wdata = cmd.sweep ? {build_cnt, build_map} : {new_cnt, new_map};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[ram_waddr] <= 1'b1;
    end
  end

  scmr_ram #(
    .WIDTH (scmr_pkg::ENTRY_W),
    .DEPTH (scmr_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.load),
    .raddr (in_slot_sel),
    .rdata (rd_entry)
  );

  // results
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r;
  logic [MW-1:0] out_map_r;
  logic [NW-1:0] out_free_r;
  logic [NW-1:0] out_use_r;
  logic [NW-1:0] use_nxt;

  assign out_valid_nxt = (cmd.exec && !(is_build && range_ok)) || (cmd.sweep && sweep_last);
  assign use_nxt       = build_go ?
                         NW'({1'b0, slot_last_r} - {1'b0, slot_first_r} + NW'(1)) :
                         range_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_use_r <= use_nxt;
      if (is_build) begin
        out_status_r <= range_ok ? scmr_pkg::ST_DONE : scmr_pkg::ST_REJECT;
        out_map_r    <= '0;
        out_free_r   <= '0;
      end else begin
        out_status_r <= (is_mark && !in_range) ? scmr_pkg::ST_IGNORED : scmr_pkg::ST_DONE;
        out_map_r    <= new_map;
        out_free_r   <= new_cnt;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_chan_map     = out_map_r;
  assign out_free_chans   = out_free_r;
  assign out_slots_in_use = out_use_r;

  assign stat.build_go   = is_build && range_ok;
  assign stat.sweep_last = sweep_last;

endmodule

`default_nettype wire
